/* src/flm_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// flm_pkg
// types and codes shared by the lock manager controller and datapath
// ----------------------------------------------------------------------------
package flm_pkg;

	localparam int KIND_W = 2;
	localparam int LNUM_W = 5;
	localparam int IPID_W = 10;
	localparam int IGRP_W = 8;
	localparam int PCT_W  = 7;
	localparam int ST_W   = 3;
	localparam int LOUT_W = 4;

	// stored pid and group widths follow the transaction fields
	localparam int PID_WIDTH   = IPID_W;
	localparam int GROUP_WIDTH = IGRP_W;

	localparam logic [KIND_W-1:0] K_CREATE  = 2'd0;
	localparam logic [KIND_W-1:0] K_ACQUIRE = 2'd1;
	localparam logic [KIND_W-1:0] K_RELEASE = 2'd2;
	localparam logic [KIND_W-1:0] K_DESTROY = 2'd3;

	localparam logic [ST_W-1:0] ST_OK       = 3'd0;
	localparam logic [ST_W-1:0] ST_BAD_ID   = 3'd1;
	localparam logic [ST_W-1:0] ST_INACTIVE = 3'd2;
	localparam logic [ST_W-1:0] ST_FULL     = 3'd3;
	localparam logic [ST_W-1:0] ST_NOT_LOCK = 3'd4;
	localparam logic [ST_W-1:0] ST_NO_FREE  = 3'd5;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [LNUM_W-1:0] lock_num;
		logic [IPID_W-1:0] requester_pid;
		logic [IGRP_W-1:0] requester_group;
		logic [PCT_W-1:0]  favor_percent;
		logic [PCT_W-1:0]  random_percent;
	} req_t;

	typedef struct packed {
		logic              result_kind;
		logic [ST_W-1:0]   status;
		logic              granted_now;
		logic [LOUT_W-1:0] lock_out;
		logic [IPID_W-1:0] grant_pid;
		logic [IGRP_W-1:0] grant_group;
		logic              last;
	} rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_CREATE,
		S_ACQ,
		S_REL_HEAD,
		S_REL_SCAN,
		S_REL_SWAP,
		S_REL_GRANT,
		S_DESTROY,
		S_REPLY,
		S_GRANT_OUT
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load;
		logic create_step;
		logic do_acquire;
		logic rel_head;
		logic scan_step;
		logic do_swap;
		logic do_grant;
		logic do_destroy;
		logic emit_reply;
		logic emit_grant;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic kind_create;
		logic kind_acquire;
		logic kind_release;
		logic early_reply;
		logic create_done;
		logic rel_need_scan;
		logic rel_has_waiter;
		logic scan_hit;
		logic scan_done;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

/* src/flm_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// flm_ctrl
// sequencer for one lock manager transaction at a time
// ----------------------------------------------------------------------------
module flm_ctrl
	import flm_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_fire,
	output cmd_t      cmd,
	output logic      busy,
	input  sts_t      sts
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_fire) state_d = S_DISPATCH;
			end
			S_DISPATCH: begin
				if (sts.kind_create) state_d = S_CREATE;
				else if (sts.early_reply) state_d = S_REPLY;
				else if (sts.kind_acquire) state_d = S_ACQ;
				else if (sts.kind_release) state_d = S_REL_HEAD;
				else state_d = S_DESTROY;
			end
			S_CREATE: begin
				if (sts.create_done) state_d = S_REPLY;
			end
			S_ACQ:     state_d = S_REPLY;
			S_DESTROY: state_d = S_REPLY;
			S_REL_HEAD: begin
				if (sts.rel_need_scan) state_d = S_REL_SCAN;
				else if (sts.rel_has_waiter) state_d = S_REL_GRANT;
				else state_d = S_REPLY;
			end
			S_REL_SCAN: begin
				if (sts.scan_hit) state_d = S_REL_SWAP;
				else if (sts.scan_done) state_d = S_REL_GRANT;
			end
			S_REL_SWAP:  state_d = S_REL_GRANT;
			S_REL_GRANT: state_d = S_REPLY;
			S_REPLY: begin
				if (sts.out_free) state_d = sts.rel_has_waiter ? S_GRANT_OUT : S_IDLE;
			end
			S_GRANT_OUT: begin
				if (sts.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			S_IDLE: begin
				busy     = 1'b0;
				cmd.load = in_fire;
			end
			S_CREATE:    cmd.create_step = 1'b1;
			S_ACQ:       cmd.do_acquire  = 1'b1;
			S_DESTROY:   cmd.do_destroy  = 1'b1;
			S_REL_HEAD:  cmd.rel_head    = 1'b1;
			S_REL_SCAN:  cmd.scan_step   = !sts.scan_hit;
			S_REL_SWAP:  cmd.do_swap     = 1'b1;
			S_REL_GRANT: cmd.do_grant    = 1'b1;
			S_REPLY:     cmd.emit_reply  = sts.out_free;
			S_GRANT_OUT: cmd.emit_grant  = sts.out_free;
			default: ;
		endcase
	end

endmodule
`default_nettype wire

/* src/flm_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// flm_dp
// lock slot table, waiter queue memory and result register
// ----------------------------------------------------------------------------
module flm_dp
	import flm_pkg::*;
#(
	parameter int NUM_LOCKS   = 16,
	parameter int QUEUE_DEPTH = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  req_t      req,
	input  cmd_t      cmd,
	output sts_t      sts,
	output rsp_t      rsp,
	output logic      rsp_valid,
	input  wire logic rsp_stall
);

	localparam int SW = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
	localparam int QW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int MW = SW + QW;
	localparam int MD = NUM_LOCKS * (1 << QW);
	localparam int EW = PID_WIDTH + GROUP_WIDTH;

	logic [NUM_LOCKS-1:0]   active_q, locked_q;
	logic [PCT_W-1:0]       favor_q  [NUM_LOCKS];
	logic [PID_WIDTH-1:0]   hpid_q   [NUM_LOCKS];
	logic [GROUP_WIDTH-1:0] hgrp_q   [NUM_LOCKS];
	logic [QW-1:0]          head_q   [NUM_LOCKS];
	logic [QW-1:0]          tail_q   [NUM_LOCKS];
	logic [CW-1:0]          cnt_q    [NUM_LOCKS];

	logic [EW-1:0] mem_q [MD];

	req_t            req_q;
	logic [SW-1:0]   slot_q;
	logic [SW:0]     cscan_q;
	logic [ST_W-1:0] st_q;
	logic            gnow_q, haswait_q, early_q;
	logic [PID_WIDTH-1:0]   rpid_q, gpid_q;
	logic [GROUP_WIDTH-1:0] rgrp_q, ggrp_q, prev_q;
	logic [QW-1:0]   head_w_q, idx_q;
	logic [CW-1:0]   cnt_w_q, i_q;
	logic [EW-1:0]   rd_q, head_e_q;
	logic            needscan_q;
	logic            rd_phase_q;
	logic            disp_q;
	logic            scan_valid_q;

	rsp_t out_q;
	logic out_v_q;

	logic          bad_id;
	logic [SW-1:0] s_in;
	logic [MW-1:0] rd_addr;
	logic [QW:0]   scan_sum;
	logic [QW-1:0] scan_idx;
	logic          scan_go;
	logic          scan_hit;

	// queue pointer step with wrap at the queue depth
	function automatic logic [QW-1:0] qinc(input logic [QW-1:0] p);
		qinc = (p == QW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign bad_id = {27'd0, req_q.lock_num} >= NUM_LOCKS;
	assign s_in   = req_q.lock_num[SW-1:0];
	assign scan_sum = {1'b0, head_w_q} + (QW+1)'(i_q);
	assign scan_idx = (scan_sum >= (QW+1)'(QUEUE_DEPTH)) ?
		QW'(scan_sum - (QW+1)'(QUEUE_DEPTH)) : scan_sum[QW-1:0];
	// only issue reads for entries still inside the queue
	assign scan_go  = cmd.scan_step && i_q < cnt_w_q;

	// memory read address for head fetch and scan
	always_comb begin
		if (cmd.load || !rd_phase_q) rd_addr = {s_in, head_q[s_in]};
		else rd_addr = {slot_q, scan_idx};
	end

	always_ff @(posedge clk) begin
		// hold the matching entry for the swap
		if (!scan_hit) rd_q <= mem_q[rd_addr];
		if (cmd.do_acquire && !early_q && !(!locked_q[slot_q] && cnt_q[slot_q] == '0)
		    && cnt_q[slot_q] < CW'(QUEUE_DEPTH))
			mem_q[{slot_q, tail_q[slot_q]}] <= {rpid_q, rgrp_q};
		if (cmd.do_swap) begin
			mem_q[{slot_q, head_w_q}] <= rd_q;
			mem_q[{slot_q, idx_q}]    <= head_e_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= '0;
			locked_q   <= '0;
			for (int k = 0; k < NUM_LOCKS; k++) begin
				favor_q[k] <= '0; hpid_q[k] <= '0; hgrp_q[k] <= '0;
				head_q[k]  <= '0; tail_q[k] <= '0; cnt_q[k]  <= '0;
			end
			out_v_q    <= 1'b0;
			rd_phase_q <= 1'b0;
			cscan_q    <= '0;
			disp_q     <= 1'b0;
		end else begin
			disp_q <= cmd.load;
			if (out_v_q && !rsp_stall) out_v_q <= 1'b0;
			if (cmd.load) begin
				cscan_q    <= '0;
				rd_phase_q <= 1'b0;
			end
			if (cmd.create_step && !active_q[cscan_q[SW-1:0]] &&
			    cscan_q < (SW+1)'(NUM_LOCKS)) begin
				active_q[cscan_q[SW-1:0]] <= 1'b1;
				favor_q[cscan_q[SW-1:0]]  <= req_q.favor_percent;
			end
			if (cmd.create_step) cscan_q <= cscan_q + 1'b1;
			if (cmd.do_acquire && !early_q) begin
				if (!locked_q[slot_q] && cnt_q[slot_q] == '0) begin
					locked_q[slot_q] <= 1'b1;
					hpid_q[slot_q]   <= rpid_q;
					hgrp_q[slot_q]   <= rgrp_q;
				end else if (cnt_q[slot_q] < CW'(QUEUE_DEPTH)) begin
					tail_q[slot_q] <= qinc(tail_q[slot_q]);
					cnt_q[slot_q]  <= cnt_q[slot_q] + 1'b1;
				end
			end
			if (cmd.rel_head) rd_phase_q <= 1'b1;
			if (cmd.do_grant) begin
				head_q[slot_q] <= qinc(head_w_q);
				cnt_q[slot_q]  <= cnt_w_q - 1'b1;
				locked_q[slot_q] <= 1'b1;
				hpid_q[slot_q] <= gpid_q;
				hgrp_q[slot_q] <= ggrp_q;
			end
			if (cmd.rel_head && !haswait_q) begin
				locked_q[slot_q] <= 1'b0;
				hpid_q[slot_q]   <= '0;
				hgrp_q[slot_q]   <= '0;
			end
			if (cmd.do_destroy) begin
				active_q[slot_q] <= 1'b0; locked_q[slot_q] <= 1'b0;
				favor_q[slot_q]  <= '0;  hpid_q[slot_q]   <= '0;
				hgrp_q[slot_q]   <= '0;  head_q[slot_q]   <= '0;
				tail_q[slot_q]   <= '0;  cnt_q[slot_q]    <= '0;
			end
			if (cmd.emit_reply || cmd.emit_grant) out_v_q <= 1'b1;
		end
	end

	// transaction payload and scratch registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q  <= req;
			rpid_q <= req.requester_pid[PID_WIDTH-1:0];
			rgrp_q <= req.requester_group[GROUP_WIDTH-1:0];
		end
		if (cmd.load) begin
			haswait_q <= 1'b0;
			gnow_q    <= 1'b0;
		end
		if (disp_q) begin
			// dispatch cycle: settle early replies
			slot_q  <= s_in;
			early_q <= 1'b0;
			st_q    <= ST_OK;
			if (req_q.kind != K_CREATE) begin
				if (bad_id) begin
					early_q <= 1'b1; st_q <= ST_BAD_ID;
				end else if (!active_q[s_in]) begin
					early_q <= 1'b1; st_q <= ST_INACTIVE;
				end else if (req_q.kind == K_RELEASE && !locked_q[s_in]) begin
					early_q <= 1'b1; st_q <= ST_NOT_LOCK;
				end
			end
			head_w_q <= head_q[s_in];
			cnt_w_q  <= cnt_q[s_in];
			prev_q   <= hgrp_q[s_in];
			haswait_q <= cnt_q[s_in] != '0;
			needscan_q <= cnt_q[s_in] > CW'(1) && favor_q[s_in] != '0 &&
			              req_q.random_percent < favor_q[s_in];
			i_q <= CW'(1);
		end
		if (cmd.create_step) begin
			if (cscan_q >= (SW+1)'(NUM_LOCKS)) st_q <= ST_NO_FREE;
			else if (!active_q[cscan_q[SW-1:0]]) slot_q <= cscan_q[SW-1:0];
		end
		if (cmd.do_acquire && !early_q) begin
			if (!locked_q[slot_q] && cnt_q[slot_q] == '0) gnow_q <= 1'b1;
			else if (cnt_q[slot_q] >= CW'(QUEUE_DEPTH)) st_q <= ST_FULL;
		end
		if (cmd.rel_head) begin
			head_e_q <= rd_q;
			needscan_q <= needscan_q && rd_q[GROUP_WIDTH-1:0] != prev_q;
			gpid_q <= rd_q[EW-1:GROUP_WIDTH];
			ggrp_q <= rd_q[GROUP_WIDTH-1:0];
		end
		if (scan_go) begin
			i_q   <= i_q + 1'b1;
			idx_q <= scan_idx;
		end
		if (cmd.do_swap) begin
			gpid_q <= rd_q[EW-1:GROUP_WIDTH];
			ggrp_q <= rd_q[GROUP_WIDTH-1:0];
		end
	end

	// scan compares the registered read of the previous index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) scan_valid_q <= 1'b0;
		else scan_valid_q <= scan_go;
	end

	assign scan_hit = scan_valid_q && rd_q[GROUP_WIDTH-1:0] == prev_q;

	always_comb begin
		sts                = '0;
		sts.kind_create    = req_q.kind == K_CREATE;
		sts.kind_acquire   = req_q.kind == K_ACQUIRE;
		sts.kind_release   = req_q.kind == K_RELEASE;
		sts.early_reply    = req_q.kind != K_CREATE && (bad_id || !active_q[s_in] ||
		                     (req_q.kind == K_RELEASE && !locked_q[s_in]));
		sts.create_done    = cscan_q >= (SW+1)'(NUM_LOCKS) || !active_q[cscan_q[SW-1:0]];
		sts.rel_need_scan  = needscan_q && rd_q[GROUP_WIDTH-1:0] != prev_q;
		sts.rel_has_waiter = haswait_q && req_q.kind == K_RELEASE && !early_q;
		sts.scan_hit       = scan_hit;
		sts.scan_done      = i_q >= cnt_w_q && !scan_valid_q;
		sts.out_free       = !out_v_q || !rsp_stall;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_reply) begin
			out_q.result_kind <= 1'b0;
			out_q.status      <= st_q;
			out_q.granted_now <= gnow_q;
			out_q.lock_out    <= (req_q.kind == K_CREATE) ?
				((st_q == ST_OK) ? LOUT_W'(slot_q) : '0) : req_q.lock_num[LOUT_W-1:0];
			out_q.grant_pid   <= gnow_q ? IPID_W'(rpid_q) : '0;
			out_q.grant_group <= gnow_q ? IGRP_W'(rgrp_q) : '0;
			out_q.last        <= !(haswait_q && req_q.kind == K_RELEASE && !early_q);
		end
		if (cmd.emit_grant) begin
			out_q.result_kind <= 1'b1;
			out_q.status      <= ST_OK;
			out_q.granted_now <= 1'b0;
			out_q.lock_out    <= req_q.lock_num[LOUT_W-1:0];
			out_q.grant_pid   <= IPID_W'(gpid_q);
			out_q.grant_group <= IGRP_W'(ggrp_q);
			out_q.last        <= 1'b1;
		end
	end

	assign rsp       = out_q;
	assign rsp_valid = out_v_q;

endmodule
`default_nettype wire

/* src/fifo_lock_manager_group_favor.sv */
`default_nettype none
// one transaction at a time: in_stall stays high until the reply, and any waiter grant,
// has been loaded into the output register, which holds it while out_stall is high.
// create walks the slot table one slot a cycle, release walks the waiter queue one entry
// a cycle through the single queue memory read port.
// reset clears all slot state at once; waiter memory is not cleared.
// ----------------------------------------------------------------------------
// fifo_lock_manager_group_favor
// lock manager with fifo waiter queues and group favor on release
// ----------------------------------------------------------------------------
module fifo_lock_manager_group_favor
	import flm_pkg::*;
#(
	parameter int NUM_LOCKS   = 16,
	parameter int QUEUE_DEPTH = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_stall,
	input  req_t      in_data,
	output logic      out_valid,
	input  wire logic out_stall,
	output rsp_t      out_data
);

	cmd_t cmd;
	sts_t sts;
	logic busy;

	assign in_stall = busy;

	flm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_valid && !busy),
		.cmd(cmd), .busy(busy), .sts(sts)
	);

	flm_dp #(
		.NUM_LOCKS(NUM_LOCKS), .QUEUE_DEPTH(QUEUE_DEPTH)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .req(in_data), .cmd(cmd), .sts(sts),
		.rsp(out_data), .rsp_valid(out_valid), .rsp_stall(out_stall)
	);

endmodule
`default_nettype wire

/* verif/tb_fifo_lock_manager_group_favor.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tb_fifo_lock_manager_group_favor
// self-checking bench for the lock manager: a behavioral copy of the slot table
// and waiter queues predicts every reply and grant, results are compared in order
// ----------------------------------------------------------------------------
module tb_fifo_lock_manager_group_favor;
	import flm_pkg::*;

	localparam int NLOCK = 16;
	localparam int QDEP  = 16;
	localparam int WATCHDOG_LIMIT = 20000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	req_t in_data;
	logic out_valid;
	logic out_stall;
	rsp_t out_data;

	fifo_lock_manager_group_favor dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// lock table mirror
	bit        lk_active [NLOCK];
	bit        lk_locked [NLOCK];
	bit [6:0]  lk_favor  [NLOCK];
	bit [9:0]  lk_hpid   [NLOCK];
	bit [7:0]  lk_hgrp   [NLOCK];
	bit [9:0]  wq_pid    [NLOCK][QDEP];
	bit [7:0]  wq_grp    [NLOCK][QDEP];
	int        wq_head   [NLOCK];
	int        wq_tail   [NLOCK];
	int        wq_count  [NLOCK];

	rsp_t pending_rsp[$];
	int   n_errors;
	int   n_sent;
	int   n_results;
	int   n_grants;
	int   n_favor_swaps;
	int   idle_cycles;
	bit   out_gaps_on;

	function automatic rsp_t mk_rsp(bit rk, logic [ST_W-1:0] st, bit gn, bit [3:0] lk,
			bit [9:0] pid, bit [7:0] grp, bit lst);
		rsp_t r;
		r.result_kind = rk;
		r.status      = st;
		r.granted_now = gn;
		r.lock_out    = lk;
		r.grant_pid   = pid;
		r.grant_group = grp;
		r.last        = lst;
		return r;
	endfunction

	function automatic void wipe_slot(int s);
		lk_active[s] = 0;
		lk_locked[s] = 0;
		lk_favor[s]  = 0;
		lk_hpid[s]   = 0;
		lk_hgrp[s]   = 0;
		wq_head[s]   = 0;
		wq_tail[s]   = 0;
		wq_count[s]  = 0;
	endfunction

	// works out the replies and grants one request causes
	function automatic void predict_lock_op(req_t rq);
		int s;
		int hd;
		int idx;
		bit [9:0] tp;
		bit [7:0] tg;
		bit [7:0] prev;
		if (rq.kind == K_CREATE) begin
			for (s = 0; s < NLOCK; s++) begin
				if (!lk_active[s]) begin
					lk_active[s] = 1;
					lk_favor[s] = rq.favor_percent;
					pending_rsp.push_back(mk_rsp(0, ST_OK, 0, 4'(s), 0, 0, 1));
					return;
				end
			end
			pending_rsp.push_back(mk_rsp(0, ST_NO_FREE, 0, 0, 0, 0, 1));
			return;
		end
		if (rq.lock_num >= NLOCK) begin
			pending_rsp.push_back(mk_rsp(0, ST_BAD_ID, 0, rq.lock_num[3:0], 0, 0, 1));
			return;
		end
		s = int'(rq.lock_num);
		if (!lk_active[s]) begin
			pending_rsp.push_back(mk_rsp(0, ST_INACTIVE, 0, 4'(s), 0, 0, 1));
			return;
		end
		case (rq.kind)
			K_ACQUIRE: begin
				if (!lk_locked[s] && wq_count[s] == 0) begin
					lk_locked[s] = 1;
					lk_hpid[s] = rq.requester_pid;
					lk_hgrp[s] = rq.requester_group;
					pending_rsp.push_back(mk_rsp(0, ST_OK, 1, 4'(s), rq.requester_pid,
						rq.requester_group, 1));
				end else if (wq_count[s] >= QDEP) begin
					pending_rsp.push_back(mk_rsp(0, ST_FULL, 0, 4'(s), 0, 0, 1));
				end else begin
					wq_pid[s][wq_tail[s]] = rq.requester_pid;
					wq_grp[s][wq_tail[s]] = rq.requester_group;
					wq_tail[s] = (wq_tail[s] + 1) % QDEP;
					wq_count[s]++;
					pending_rsp.push_back(mk_rsp(0, ST_OK, 0, 4'(s), 0, 0, 1));
				end
			end
			K_RELEASE: begin
				if (!lk_locked[s]) begin
					pending_rsp.push_back(mk_rsp(0, ST_NOT_LOCK, 0, 4'(s), 0, 0, 1));
					return;
				end
				prev = lk_hgrp[s];
				lk_locked[s] = 0;
				lk_hpid[s] = 0;
				lk_hgrp[s] = 0;
				hd = wq_head[s];
				if (wq_count[s] > 1 && lk_favor[s] > 0 && rq.random_percent < lk_favor[s]
						&& wq_grp[s][hd] != prev) begin
					for (int i = 1; i < wq_count[s]; i++) begin
						idx = (hd + i) % QDEP;
						if (wq_grp[s][idx] == prev) begin
							tp = wq_pid[s][hd];
							tg = wq_grp[s][hd];
							wq_pid[s][hd] = wq_pid[s][idx];
							wq_grp[s][hd] = wq_grp[s][idx];
							wq_pid[s][idx] = tp;
							wq_grp[s][idx] = tg;
							n_favor_swaps++;
							break;
						end
					end
				end
				if (wq_count[s] == 0) begin
					pending_rsp.push_back(mk_rsp(0, ST_OK, 0, 4'(s), 0, 0, 1));
					return;
				end
				lk_locked[s] = 1;
				lk_hpid[s] = wq_pid[s][hd];
				lk_hgrp[s] = wq_grp[s][hd];
				wq_head[s] = (hd + 1) % QDEP;
				wq_count[s]--;
				pending_rsp.push_back(mk_rsp(0, ST_OK, 0, 4'(s), 0, 0, 0));
				pending_rsp.push_back(mk_rsp(1, ST_OK, 0, 4'(s), lk_hpid[s], lk_hgrp[s], 1));
			end
			default: begin
				wipe_slot(s);
				pending_rsp.push_back(mk_rsp(0, ST_OK, 0, 4'(s), 0, 0, 1));
			end
		endcase
	endfunction

	// sends one transaction after a random gap
	task automatic send_op(logic [1:0] k, logic [4:0] num, logic [9:0] pid = 0,
			logic [7:0] grp = 0, logic [6:0] fav = 0, logic [6:0] rnd = 0,
			bit no_gap = 0);
		req_t rq;
		int gap;
		rq.kind = k;
		rq.lock_num = num;
		rq.requester_pid = pid;
		rq.requester_group = grp;
		rq.favor_percent = fav;
		rq.random_percent = rnd;
		gap = no_gap ? 0 : $urandom_range(0, 5);
		if (gap != 0) begin
			in_valid <= 1'b0;
			in_data  <= req_t'($urandom());
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= rq;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_lock_op(rq);
		n_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		in_data  <= req_t'($urandom());
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	// result checker and receiver stalls
	always @(posedge clk) begin
		rsp_t exp_r;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				n_results++;
				if (pending_rsp.size() == 0) begin
					$error("unexpected result %h", out_data);
					n_errors++;
				end else begin
					exp_r = pending_rsp.pop_front();
					if (out_data.result_kind == 1'b1) n_grants++;
					if (out_data.result_kind !== exp_r.result_kind) begin
						$error("result_kind exp %0d got %0d", exp_r.result_kind,
							out_data.result_kind);
						n_errors++;
					end
					if (out_data.status !== exp_r.status) begin
						$error("status exp %0d got %0d", exp_r.status, out_data.status);
						n_errors++;
					end
					if (out_data.granted_now !== exp_r.granted_now) begin
						$error("granted_now exp %0d got %0d", exp_r.granted_now,
							out_data.granted_now);
						n_errors++;
					end
					if (out_data.lock_out !== exp_r.lock_out) begin
						$error("lock_out exp %0d got %0d", exp_r.lock_out, out_data.lock_out);
						n_errors++;
					end
					if (out_data.grant_pid !== exp_r.grant_pid) begin
						$error("grant_pid exp %0d got %0d", exp_r.grant_pid,
							out_data.grant_pid);
						n_errors++;
					end
					if (out_data.grant_group !== exp_r.grant_group) begin
						$error("grant_group exp %0d got %0d", exp_r.grant_group,
							out_data.grant_group);
						n_errors++;
					end
					if (out_data.last !== exp_r.last) begin
						$error("last exp %0d got %0d", exp_r.last, out_data.last);
						n_errors++;
					end
				end
			end
			out_stall <= out_gaps_on ? ($urandom_range(0, 5) != 0 && $urandom_range(0, 2) == 0)
				: 1'b0;
		end
	end

	// watchdog on cycles with no transaction
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic test_table_limits();
		for (int i = 0; i < NLOCK; i++)
			send_op(K_CREATE, 0, 0, 0, (i == 0) ? 7'd0 : (i == 1) ? 7'd100 : 7'd127);
		send_op(K_CREATE, 0, 0, 0, 7'd50);
		send_op(K_ACQUIRE, 5'd16);
		send_op(K_RELEASE, 5'd31);
		send_op(K_DESTROY, 5'd20);
		send_op(K_RELEASE, 5'd3, 0, 0, 0, 7'd127);
		send_op(K_DESTROY, 5'd15);
		send_op(K_ACQUIRE, 5'd15, 10'h3ff, 8'hff);
		send_op(K_RELEASE, 5'd15);
		send_op(K_CREATE, 0, 0, 0, 7'd127);
		wait_drained();
	endtask

	task automatic test_queue_full_and_favor();
		// slot 1 has favor 100: fill the queue with mixed groups
		send_op(K_ACQUIRE, 5'd1, 10'd1, 8'd7);
		for (int i = 0; i < QDEP; i++)
			send_op(K_ACQUIRE, 5'd1, 10'(100 + i), (i % 4 == 3) ? 8'd7 : 8'd9);
		send_op(K_ACQUIRE, 5'd1, 10'd999, 8'd7);
		send_op(K_RELEASE, 5'd1, 0, 0, 0, 7'd99);
		send_op(K_RELEASE, 5'd1, 0, 0, 0, 7'd0);
		// slot 0 has favor 0: never swaps
		send_op(K_ACQUIRE, 5'd0, 10'd2, 8'd3);
		send_op(K_ACQUIRE, 5'd0, 10'd3, 8'd4);
		send_op(K_ACQUIRE, 5'd0, 10'd4, 8'd3);
		send_op(K_RELEASE, 5'd0, 0, 0, 0, 7'd0);
		send_op(K_DESTROY, 5'd1);
		send_op(K_ACQUIRE, 5'd0, 10'd5, 8'd0);
		send_op(K_DESTROY, 5'd0);
		wait_drained();
	endtask

	// mostly well-formed lock traffic on a few slots, with some noise
	task automatic test_random_traffic(int n_items);
		int s;
		logic [1:0] k;
		for (int i = 0; i < n_items; i++) begin
			if (i % 200 == 100) out_gaps_on = 0;
			if (i % 200 == 0) out_gaps_on = 1;
			s = $urandom_range(0, 99) < 90 ? $urandom_range(0, 5) : $urandom_range(0, 31);
			case ($urandom_range(0, 19))
				0: k = K_CREATE;
				1: k = K_DESTROY;
				2, 3, 4, 5, 6, 7: k = K_RELEASE;
				default: k = K_ACQUIRE;
			endcase
			send_op(k, 5'(s), 10'($urandom_range(0, 1023)),
				8'($urandom_range(0, 3) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 2)),
				7'($urandom_range(0, 3) == 0 ? $urandom_range(0, 127) : $urandom_range(0, 100)),
				7'($urandom_range(0, 7) == 0 ? $urandom_range(0, 127) : $urandom_range(0, 99)),
				i % 150 < 20);
		end
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		out_gaps_on = 1;
		n_errors = 0;
		n_sent = 0;
		n_results = 0;
		n_grants = 0;
		n_favor_swaps = 0;
		idle_cycles = 0;
		for (int s = 0; s < NLOCK; s++) wipe_slot(s);
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_table_limits();
		test_queue_full_and_favor();
		test_random_traffic(900);
		$display("sent %0d requests, checked %0d results", n_sent, n_results);
		$display("waiter grants %0d, group favor swaps %0d", n_grants, n_favor_swaps);
		if (n_errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
`default_nettype wire
